// ===== hdl/dtpm_pkg.sv =====
// Shared constants, codes and control structs of the dead-time plant model step.
`timescale 1ns / 1ps
`default_nettype none

package dtpm_pkg;

  localparam int unsigned MAX_DEAD_TIME = 13;

  localparam int unsigned CTRL_W     = 16;
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned OUT_W      = 15;
  localparam int unsigned FLAG_W     = 2;
  localparam int unsigned DT_W       = 4;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned TERM_W     = 48;
  localparam int unsigned ACC_W      = 50;
  localparam int unsigned LINE_AGE_W = 8;

  localparam logic [OUT_W-1:0] OUT_MAX   = 15'd30720;
  localparam logic [OUT_W-1:0] OUT_RESET = 15'd2560;

  localparam logic signed [COEF_W-1:0] GAIN_RST     = 32'sd328;
  localparam logic signed [COEF_W-1:0] COEF_A_RST   = 32'sd18233229;
  localparam logic signed [COEF_W-1:0] COEF_B_RST   = 32'sd14812840;
  localparam logic signed [COEF_W-1:0] COEF_C_RST   = -32'sd2368012;
  localparam logic signed [COEF_W-1:0] FEEDBACK_RST = 32'sd7101;
  localparam logic [DT_W-1:0]          DEAD_TIME_RST = 4'd3;

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN      = 3'd0,
    REG_COEF_A    = 3'd1,
    REG_COEF_B    = 3'd2,
    REG_COEF_C    = 3'd3,
    REG_FEEDBACK  = 3'd4,
    REG_DEAD_TIME = 3'd5
  } reg_idx_t;

  typedef enum logic [FLAG_W-1:0] {
    FLAG_NONE = 2'd0,
    FLAG_LOW  = 2'd1,
    FLAG_HIGH = 2'd2
  } clamp_flag_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GAIN,
    S_SCALE,
    S_RD_A,
    S_MUL_A,
    S_MUL_B,
    S_MUL_C,
    S_MUL_F,
    S_SUM,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    MUL_GAIN,
    MUL_A,
    MUL_B,
    MUL_C,
    MUL_FB
  } mul_sel_t;

  typedef struct packed {
    logic     mul_en;
    mul_sel_t sel;
    logic     acc_clr;
    logic     acc_add;
    logic     term_fb;
  } mac_ctl_t;

  typedef struct packed {
    logic                  wr_en;
    logic                  rd_en;
    logic [LINE_AGE_W-1:0] rd_age;
  } line_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/dtpm_in_if.sv =====
// Input channel: one control value per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface dtpm_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [dtpm_pkg::CTRL_W-1:0]     control_in;

  modport source (output valid, output control_in, input ready);
  modport sink   (input valid, input control_in, output ready);
endinterface

`default_nettype wire

// ===== hdl/dtpm_out_if.sv =====
// Output channel: plant output and clamp flag per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface dtpm_out_if;
  logic                          valid;
  logic                          ready;
  logic [dtpm_pkg::OUT_W-1:0]    plant_out;
  logic [dtpm_pkg::FLAG_W-1:0]   clamp_flag;

  modport source (output valid, output plant_out, output clamp_flag, input ready);
  modport sink   (input valid, input plant_out, input clamp_flag, output ready);
endinterface

`default_nettype wire

// ===== hdl/dtpm_mac.sv =====
// Shared 32x32 multiplier with product register, saturating scaler and accumulator.
`timescale 1ns / 1ps
`default_nettype none

module dtpm_mac (
  input  wire logic                                  clk,
  input  wire dtpm_pkg::mac_ctl_t                    ctl,
  input  wire logic signed [dtpm_pkg::COEF_W-1:0]    input_gain,
  input  wire logic signed [dtpm_pkg::COEF_W-1:0]    coef_a,
  input  wire logic signed [dtpm_pkg::COEF_W-1:0]    coef_b,
  input  wire logic signed [dtpm_pkg::COEF_W-1:0]    coef_c,
  input  wire logic signed [dtpm_pkg::COEF_W-1:0]    feedback_coef,
  input  wire logic signed [dtpm_pkg::CTRL_W-1:0]    ctrl_val,
  input  wire logic signed [dtpm_pkg::COEF_W-1:0]    line_val,
  input  wire logic        [dtpm_pkg::OUT_W-1:0]     older,
  output logic signed      [dtpm_pkg::COEF_W-1:0]    scaled,
  output logic signed      [dtpm_pkg::ACC_W-1:0]     acc
);

  logic signed [dtpm_pkg::COEF_W-1:0] op_x;
  logic signed [dtpm_pkg::COEF_W-1:0] op_y;
  logic signed [dtpm_pkg::PROD_W-1:0] prod_full;
  logic signed [dtpm_pkg::PROD_W-1:0] prod;
  logic signed [dtpm_pkg::TERM_W-1:0] term;

  always_comb begin
    op_x = '0;
    op_y = '0;
    unique case (ctl.sel)
      dtpm_pkg::MUL_GAIN: begin
        op_x = input_gain;
        op_y = {{(dtpm_pkg::COEF_W-dtpm_pkg::CTRL_W){ctrl_val[dtpm_pkg::CTRL_W-1]}}, ctrl_val};
      end
      dtpm_pkg::MUL_A: begin
        op_x = coef_a;
        op_y = line_val;
      end
      dtpm_pkg::MUL_B: begin
        op_x = coef_b;
        op_y = line_val;
      end
      dtpm_pkg::MUL_C: begin
        op_x = coef_c;
        op_y = line_val;
      end
      dtpm_pkg::MUL_FB: begin
        op_x = feedback_coef;
        op_y = {{(dtpm_pkg::COEF_W-dtpm_pkg::OUT_W){1'b0}}, older};
      end
      default: begin
        op_x = '0;
        op_y = '0;
      end
    endcase
  end

  assign prod_full = op_x * op_y;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= prod_full;
    end
  end

  // Feedback product is Q40.24 (drop 8 bits), the others Q32.32 (drop 16).
  assign term = ctl.term_fb ? prod[55:8] : prod[63:16];

  always_ff @(posedge clk) begin
    if (ctl.acc_clr) begin
      acc <= '0;
    end else if (ctl.acc_add) begin
      acc <= acc + {{(dtpm_pkg::ACC_W-dtpm_pkg::TERM_W){term[dtpm_pkg::TERM_W-1]}}, term};
    end
  end

  // Floor shift by 8 then saturate to 32 bits signed.
  always_comb begin
    if (prod[63:39] == '0 || prod[63:39] == '1) begin
      scaled = prod[39:8];
    end else if (prod[63]) begin
      scaled = {1'b1, {(dtpm_pkg::COEF_W-1){1'b0}}};
    end else begin
      scaled = {1'b0, {(dtpm_pkg::COEF_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dtpm_line.sv =====
// Dead-time delay line: circular buffer memory with per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none

module dtpm_line #(
  parameter int unsigned Depth = dtpm_pkg::MAX_DEAD_TIME + 3
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire dtpm_pkg::line_ctl_t                   ctl,
  input  wire logic signed [dtpm_pkg::COEF_W-1:0]    wr_data,
  output logic signed      [dtpm_pkg::COEF_W-1:0]    rd_data
);

  localparam int unsigned AW = $clog2(Depth);
  localparam logic [AW:0] DepthW = (AW+1)'(Depth);

  logic signed [dtpm_pkg::COEF_W-1:0] mem [Depth];
  logic [Depth-1:0]                   valid;
  logic [AW-1:0]                      head;
  logic [AW-1:0]                      wr_addr;
  logic [AW-1:0]                      rd_addr;
  logic [AW:0]                        rd_sum;
  logic signed [dtpm_pkg::COEF_W-1:0] rd_q;
  logic                               rd_vld;

  // Newest entry sits at head; age k lives at head + k, wrapped.
  assign wr_addr = (head == '0) ? AW'(Depth - 1) : head - 1'b1;
  assign rd_sum  = {1'b0, head} + {1'b0, AW'(ctl.rd_age)};
  assign rd_addr = (rd_sum >= DepthW) ? AW'(rd_sum - DepthW) : rd_sum[AW-1:0];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        head           <= wr_addr;
        valid[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld <= valid[rd_addr];
      end
    end
  end

  // Entries never written read as zero.
  assign rd_data = rd_vld ? rd_q : '0;

`ifndef SYNTH
  a_no_rd_wr_same_cycle: assert property (@(posedge clk) disable iff (rst)
    !(ctl.wr_en && ctl.rd_en))
    else $error("delay line read and write in one cycle");

  a_head_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, head} < DepthW)
    else $error("delay line head out of range");

  a_write_advances_head: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_en |=> valid[head])
    else $error("written entry not marked valid at new head");
`endif

endmodule

`default_nettype wire

// ===== hdl/dtpm_seq.sv =====
// Step sequencer: drives the shared multiplier and the delay line port.
`timescale 1ns / 1ps
`default_nettype none

module dtpm_seq #(
  parameter int unsigned MaxDeadTime = dtpm_pkg::MAX_DEAD_TIME
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic [dtpm_pkg::DT_W-1:0]      dead_time,
  input  wire logic                           out_free,
  output logic                                in_ready,
  output dtpm_pkg::mac_ctl_t                  mac_ctl,
  output dtpm_pkg::line_ctl_t                 line_ctl,
  output logic                                out_load
);

  dtpm_pkg::state_t state;
  dtpm_pkg::state_t state_next;

  logic [dtpm_pkg::LINE_AGE_W-1:0] z;

  // Clamp the dead time to MaxDeadTime.
  assign z = (32'(dead_time) > 32'(MaxDeadTime)) ? dtpm_pkg::LINE_AGE_W'(MaxDeadTime)
                                                 : dtpm_pkg::LINE_AGE_W'(dead_time);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtpm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dtpm_pkg::S_IDLE:  if (in_valid) state_next = dtpm_pkg::S_GAIN;
      dtpm_pkg::S_GAIN:  state_next = dtpm_pkg::S_SCALE;
      dtpm_pkg::S_SCALE: state_next = dtpm_pkg::S_RD_A;
      dtpm_pkg::S_RD_A:  state_next = dtpm_pkg::S_MUL_A;
      dtpm_pkg::S_MUL_A: state_next = dtpm_pkg::S_MUL_B;
      dtpm_pkg::S_MUL_B: state_next = dtpm_pkg::S_MUL_C;
      dtpm_pkg::S_MUL_C: state_next = dtpm_pkg::S_MUL_F;
      dtpm_pkg::S_MUL_F: state_next = dtpm_pkg::S_SUM;
      dtpm_pkg::S_SUM:   state_next = dtpm_pkg::S_OUT;
      dtpm_pkg::S_OUT:   if (out_free) state_next = dtpm_pkg::S_IDLE;
      default:           state_next = dtpm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    out_load         = 1'b0;
    mac_ctl.mul_en   = 1'b0;
    mac_ctl.sel      = dtpm_pkg::MUL_GAIN;
    mac_ctl.acc_clr  = 1'b0;
    mac_ctl.acc_add  = 1'b0;
    mac_ctl.term_fb  = 1'b0;
    line_ctl.wr_en   = 1'b0;
    line_ctl.rd_en   = 1'b0;
    line_ctl.rd_age  = z;
    unique case (state)
      dtpm_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      dtpm_pkg::S_GAIN: begin
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.sel     = dtpm_pkg::MUL_GAIN;
        mac_ctl.acc_clr = 1'b1;
      end
      dtpm_pkg::S_SCALE: begin
        line_ctl.wr_en = 1'b1;
      end
      dtpm_pkg::S_RD_A: begin
        line_ctl.rd_en  = 1'b1;
        line_ctl.rd_age = z;
      end
      dtpm_pkg::S_MUL_A: begin
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.sel     = dtpm_pkg::MUL_A;
        line_ctl.rd_en  = 1'b1;
        line_ctl.rd_age = z + 1'b1;
      end
      dtpm_pkg::S_MUL_B: begin
        mac_ctl.acc_add = 1'b1;
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.sel     = dtpm_pkg::MUL_B;
        line_ctl.rd_en  = 1'b1;
        line_ctl.rd_age = z + 2'd2;
      end
      dtpm_pkg::S_MUL_C: begin
        mac_ctl.acc_add = 1'b1;
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.sel     = dtpm_pkg::MUL_C;
      end
      dtpm_pkg::S_MUL_F: begin
        mac_ctl.acc_add = 1'b1;
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.sel     = dtpm_pkg::MUL_FB;
      end
      dtpm_pkg::S_SUM: begin
        mac_ctl.acc_add = 1'b1;
        mac_ctl.term_fb = 1'b1;
      end
      dtpm_pkg::S_OUT: begin
        out_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

`ifndef SYNTH
  a_accept_starts_step: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == dtpm_pkg::S_GAIN)
    else $error("accepted item did not start a step");

  a_hold_until_free: assert property (@(posedge clk) disable iff (rst)
    state == dtpm_pkg::S_OUT && !out_free |=> state == dtpm_pkg::S_OUT)
    else $error("result dropped while output slot busy");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == dtpm_pkg::S_IDLE)
    else $error("input ready outside idle");
`endif

endmodule

`default_nettype wire

// ===== hdl/dead_time_plant_model_step.sv =====
// Top level of the dead-time plant model step.
// Usage:
//   in_ch transfers one signed Q8.8 control value per plant step; out_ch
//   transfers the clamped unsigned Q7.8 plant output with its clamp flag
//   (none, clamped at zero, clamped at 120). Coefficients and dead time are
//   written through cfg_we/cfg_index/cfg_wdata, unknown indexes are ignored;
//   the user must write them only while no step is in flight (not enforced).
// Timing:
//   A step runs five products through one shared 32x32 multiplier and reads
//   three delay line entries over the line's single read port. The result is
//   loaded into the output register at the end of the step, and a new item is
//   taken only once the previous result has been loaded into it.
// Reset (rst, synchronous): registers return to their default coefficients,
//   the delay line reads as zero and both output history values are 10.0.
// Stall: a finished result sits in the output register; a following item may
//   be taken and computed, then waits in its last step until the register
//   is free. in_ch.ready is low while a step runs.
`timescale 1ns / 1ps
`default_nettype none

module dead_time_plant_model_step #(
  parameter int unsigned MaxDeadTime = dtpm_pkg::MAX_DEAD_TIME
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  dtpm_in_if.sink                               in_ch,
  dtpm_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [dtpm_pkg::IDX_W-1:0]       cfg_index,
  input  wire logic [dtpm_pkg::COEF_W-1:0]      cfg_wdata
);

  logic signed [dtpm_pkg::COEF_W-1:0] input_gain;
  logic signed [dtpm_pkg::COEF_W-1:0] coef_a;
  logic signed [dtpm_pkg::COEF_W-1:0] coef_b;
  logic signed [dtpm_pkg::COEF_W-1:0] coef_c;
  logic signed [dtpm_pkg::COEF_W-1:0] feedback_coef;
  logic        [dtpm_pkg::DT_W-1:0]   dead_time;

  logic signed [dtpm_pkg::CTRL_W-1:0] ctrl_q;
  logic [dtpm_pkg::OUT_W-1:0]         newest_output;
  logic [dtpm_pkg::OUT_W-1:0]         older_output;

  logic                               out_valid;
  logic [dtpm_pkg::OUT_W-1:0]         plant_out_q;
  dtpm_pkg::clamp_flag_t              flag_q;

  dtpm_pkg::mac_ctl_t                 mac_ctl;
  dtpm_pkg::line_ctl_t                line_ctl;
  logic                               in_ready;
  logic                               out_free;
  logic                               out_load;

  logic signed [dtpm_pkg::COEF_W-1:0] scaled;
  logic signed [dtpm_pkg::COEF_W-1:0] line_val;
  logic signed [dtpm_pkg::ACC_W-1:0]  acc;
  logic signed [dtpm_pkg::ACC_W-9:0]  res;
  logic [dtpm_pkg::OUT_W-1:0]         res_clamped;
  dtpm_pkg::clamp_flag_t              res_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_gain    <= dtpm_pkg::GAIN_RST;
      coef_a        <= dtpm_pkg::COEF_A_RST;
      coef_b        <= dtpm_pkg::COEF_B_RST;
      coef_c        <= dtpm_pkg::COEF_C_RST;
      feedback_coef <= dtpm_pkg::FEEDBACK_RST;
      dead_time     <= dtpm_pkg::DEAD_TIME_RST;
    end else if (cfg_we) begin
      unique case (dtpm_pkg::reg_idx_t'(cfg_index))
        dtpm_pkg::REG_GAIN:      input_gain    <= cfg_wdata;
        dtpm_pkg::REG_COEF_A:    coef_a        <= cfg_wdata;
        dtpm_pkg::REG_COEF_B:    coef_b        <= cfg_wdata;
        dtpm_pkg::REG_COEF_C:    coef_c        <= cfg_wdata;
        dtpm_pkg::REG_FEEDBACK:  feedback_coef <= cfg_wdata;
        dtpm_pkg::REG_DEAD_TIME: dead_time     <= cfg_wdata[dtpm_pkg::DT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      ctrl_q <= in_ch.control_in;
    end
  end

  assign in_ch.ready = in_ready;
  assign out_free    = !out_valid || out_ch.ready;

  dtpm_seq #(
    .MaxDeadTime(MaxDeadTime)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .dead_time(dead_time),
    .out_free (out_free),
    .in_ready (in_ready),
    .mac_ctl  (mac_ctl),
    .line_ctl (line_ctl),
    .out_load (out_load)
  );

  dtpm_mac u_mac (
    .clk          (clk),
    .ctl          (mac_ctl),
    .input_gain   (input_gain),
    .coef_a       (coef_a),
    .coef_b       (coef_b),
    .coef_c       (coef_c),
    .feedback_coef(feedback_coef),
    .ctrl_val     (ctrl_q),
    .line_val     (line_val),
    .older        (older_output),
    .scaled       (scaled),
    .acc          (acc)
  );

  dtpm_line #(
    .Depth(MaxDeadTime + 3)
  ) u_line (
    .clk    (clk),
    .rst    (rst),
    .ctl    (line_ctl),
    .wr_data(scaled),
    .rd_data(line_val)
  );

  // Bring the Q.16 sum to signed Q34.8 with floor, then clamp to 0..120.
  assign res = acc[dtpm_pkg::ACC_W-1:8];

  always_comb begin
    if (res[dtpm_pkg::ACC_W-9]) begin
      res_clamped = '0;
      res_flag    = dtpm_pkg::FLAG_LOW;
    end else if (res > $signed({{(dtpm_pkg::ACC_W-8-dtpm_pkg::OUT_W){1'b0}},
                                dtpm_pkg::OUT_MAX})) begin
      res_clamped = dtpm_pkg::OUT_MAX;
      res_flag    = dtpm_pkg::FLAG_HIGH;
    end else begin
      res_clamped = res[dtpm_pkg::OUT_W-1:0];
      res_flag    = dtpm_pkg::FLAG_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      newest_output <= dtpm_pkg::OUT_RESET;
      older_output  <= dtpm_pkg::OUT_RESET;
    end else if (out_load) begin
      out_valid     <= 1'b1;
      older_output  <= newest_output;
      newest_output <= res_clamped;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      plant_out_q <= res_clamped;
      flag_q      <= res_flag;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.plant_out  = plant_out_q;
  assign out_ch.clamp_flag = flag_q;

`ifndef SYNTH
  a_out_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> plant_out_q <= dtpm_pkg::OUT_MAX)
    else $error("plant output above clamp limit");

  a_flag_matches_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (flag_q == dtpm_pkg::FLAG_LOW || flag_q == dtpm_pkg::FLAG_HIGH)
      |-> (flag_q == dtpm_pkg::FLAG_LOW && plant_out_q == '0)
       || (flag_q == dtpm_pkg::FLAG_HIGH && plant_out_q == dtpm_pkg::OUT_MAX))
    else $error("clamp flag disagrees with output value");

  a_history_tracks_output: assert property (@(posedge clk) disable iff (rst)
    out_load |=> newest_output == plant_out_q && older_output == $past(newest_output))
    else $error("output history not updated with result");
`endif

endmodule

`default_nettype wire

// ===== tb/dead_time_plant_model_step_tb.sv =====
// Self-checking testbench for the dead-time plant model step: directed table, then random phases.
`timescale 1ns / 1ps

module dead_time_plant_model_step_tb;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 9;
  localparam int STEP_CYCLES   = 10;
  localparam int WATCHDOG_MAX  = 5000;
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_ITEMS   = 221;
  localparam int MAX_REPORTS   = 40;

  localparam logic [dtpm_pkg::IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [dtpm_pkg::IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {CFG_PLAUSIBLE, CFG_SMALL, CFG_WIDE} cfg_mode_t;

  typedef struct packed {
    logic [dtpm_pkg::OUT_W-1:0] plant_out;
    dtpm_pkg::clamp_flag_t      flag;
  } plant_result_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [dtpm_pkg::IDX_W-1:0]  idx;
    logic [dtpm_pkg::COEF_W-1:0] data;
    logic [dtpm_pkg::CTRL_W-1:0] ctrl;
    logic                        fixed;
    logic [dtpm_pkg::OUT_W-1:0]  want_out;
    dtpm_pkg::clamp_flag_t       want_flag;
  } stim_row_t;

  // kind, register, write data, control_in, fixed result?, plant_out, clamp_flag
  localparam stim_row_t DIRECTED_ROWS [0:47] = '{
    // reset defaults: line still empty, feedback on 10.0 only
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'h0000, 1'b1, 15'd277, dtpm_pkg::FLAG_NONE},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'h7FFF, 1'b1, 15'd277, dtpm_pkg::FLAG_NONE},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'h8000, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'h0001, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'hFFFF, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'h5555, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'hAAAA, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    // writes to unmapped indexes must change nothing
    '{ROW_CFG, REG_UNMAPPED_LO, 32'h0000_0000, 16'h0, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_CFG, REG_UNMAPPED_HI, 32'hFFFF_FFFF, 16'h0, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'h6400, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    // largest gain and coef_a, no dead time: saturating scale, both clamps
    '{ROW_CFG, dtpm_pkg::REG_GAIN, 32'h7FFF_FFFF, 16'h0, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_CFG, dtpm_pkg::REG_COEF_A, 32'h7FFF_FFFF, 16'h0, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_CFG, dtpm_pkg::REG_COEF_B, 32'h0000_0000, 16'h0, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_CFG, dtpm_pkg::REG_COEF_C, 32'h0000_0000, 16'h0, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_CFG, dtpm_pkg::REG_FEEDBACK, 32'h0000_0000, 16'h0, 1'b0, 15'd0,
      dtpm_pkg::FLAG_NONE},
    '{ROW_CFG, dtpm_pkg::REG_DEAD_TIME, 32'h0000_0000, 16'h0, 1'b0, 15'd0,
      dtpm_pkg::FLAG_NONE},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'h7FFF, 1'b1, dtpm_pkg::OUT_MAX,
      dtpm_pkg::FLAG_HIGH},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'h8000, 1'b1, 15'd0, dtpm_pkg::FLAG_LOW},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'h0000, 1'b1, 15'd0, dtpm_pkg::FLAG_NONE},
    // most negative gain, coef_a, coef_c and feedback, largest coef_b, dead time above the maximum
    '{ROW_CFG, dtpm_pkg::REG_GAIN, 32'h8000_0000, 16'h0, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_CFG, dtpm_pkg::REG_COEF_A, 32'h8000_0000, 16'h0, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_CFG, dtpm_pkg::REG_COEF_B, 32'h7FFF_FFFF, 16'h0, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_CFG, dtpm_pkg::REG_COEF_C, 32'h8000_0000, 16'h0, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_CFG, dtpm_pkg::REG_FEEDBACK, 32'h8000_0000, 16'h0, 1'b0, 15'd0,
      dtpm_pkg::FLAG_NONE},
    '{ROW_CFG, dtpm_pkg::REG_DEAD_TIME, 32'h0000_000F, 16'h0, 1'b0, 15'd0,
      dtpm_pkg::FLAG_NONE},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'h7FFF, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'h8000, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'h0000, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'h0100, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'hFF00, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    // default plant, largest feedback, maximum dead time
    '{ROW_CFG, dtpm_pkg::REG_GAIN, dtpm_pkg::GAIN_RST, 16'h0, 1'b0, 15'd0,
      dtpm_pkg::FLAG_NONE},
    '{ROW_CFG, dtpm_pkg::REG_COEF_A, dtpm_pkg::COEF_A_RST, 16'h0, 1'b0, 15'd0,
      dtpm_pkg::FLAG_NONE},
    '{ROW_CFG, dtpm_pkg::REG_COEF_B, dtpm_pkg::COEF_B_RST, 16'h0, 1'b0, 15'd0,
      dtpm_pkg::FLAG_NONE},
    '{ROW_CFG, dtpm_pkg::REG_COEF_C, dtpm_pkg::COEF_C_RST, 16'h0, 1'b0, 15'd0,
      dtpm_pkg::FLAG_NONE},
    '{ROW_CFG, dtpm_pkg::REG_FEEDBACK, 32'h7FFF_FFFF, 16'h0, 1'b0, 15'd0,
      dtpm_pkg::FLAG_NONE},
    '{ROW_CFG, dtpm_pkg::REG_DEAD_TIME, 32'(dtpm_pkg::MAX_DEAD_TIME), 16'h0, 1'b0, 15'd0,
      dtpm_pkg::FLAG_NONE},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'h3200, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'h0000, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'h8000, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'h7FFF, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_CFG, dtpm_pkg::REG_FEEDBACK, dtpm_pkg::FEEDBACK_RST, 16'h0, 1'b0, 15'd0,
      dtpm_pkg::FLAG_NONE},
    '{ROW_CFG, dtpm_pkg::REG_DEAD_TIME, 32'h0000_0001, 16'h0, 1'b0, 15'd0,
      dtpm_pkg::FLAG_NONE},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'h6400, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'h6400, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'h0000, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'h3039, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE},
    '{ROW_CFG, dtpm_pkg::REG_DEAD_TIME, 32'h0000_0002, 16'h0, 1'b0, 15'd0,
      dtpm_pkg::FLAG_NONE},
    '{ROW_ITEM, dtpm_pkg::REG_GAIN, 32'h0, 16'h1000, 1'b0, 15'd0, dtpm_pkg::FLAG_NONE}
  };

  logic clk = 1'b0;
  logic rst;
  logic                             cfg_we;
  logic [dtpm_pkg::IDX_W-1:0]       cfg_index;
  logic [dtpm_pkg::COEF_W-1:0]      cfg_wdata;

  dtpm_in_if  in_ch ();
  dtpm_out_if out_ch ();

  dead_time_plant_model_step u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // plant state and register copies used for prediction
  logic signed [dtpm_pkg::COEF_W-1:0] k_gain, k_a, k_b, k_c, k_fb;
  logic [dtpm_pkg::DT_W-1:0]          k_dead;
  logic signed [dtpm_pkg::COEF_W-1:0] scaled_ctrl_line [0:dtpm_pkg::MAX_DEAD_TIME+2];
  logic [dtpm_pkg::OUT_W-1:0]         y_newest, y_older;

  plant_result_t plant_outputs_due [$];
  int unsigned   mismatch_count = 0;
  int unsigned   sink_stall_pct = 20;
  int unsigned   sink_hold = 0;
  int unsigned   quiet_cycles = 0;
  bit            sender_burst = 1'b0;

  function automatic void reset_plant_state();
    k_gain = dtpm_pkg::GAIN_RST;
    k_a    = dtpm_pkg::COEF_A_RST;
    k_b    = dtpm_pkg::COEF_B_RST;
    k_c    = dtpm_pkg::COEF_C_RST;
    k_fb   = dtpm_pkg::FEEDBACK_RST;
    k_dead = dtpm_pkg::DEAD_TIME_RST;
    foreach (scaled_ctrl_line[i]) scaled_ctrl_line[i] = '0;
    y_newest = dtpm_pkg::OUT_RESET;
    y_older  = dtpm_pkg::OUT_RESET;
  endfunction

  function automatic plant_result_t plant_step(input logic signed [dtpm_pkg::CTRL_W-1:0] u);
    longint        scaled;
    longint        acc;
    longint        y;
    int unsigned   z;
    plant_result_t r;
    scaled = (longint'(u) * longint'(k_gain)) >>> 8;
    if (scaled > (longint'(1) <<< 31) - 1) scaled = (longint'(1) <<< 31) - 1;
    if (scaled < -(longint'(1) <<< 31)) scaled = -(longint'(1) <<< 31);
    for (int i = dtpm_pkg::MAX_DEAD_TIME + 2; i > 0; i--)
      scaled_ctrl_line[i] = scaled_ctrl_line[i-1];
    scaled_ctrl_line[0] = scaled[dtpm_pkg::COEF_W-1:0];
    z = (k_dead > dtpm_pkg::MAX_DEAD_TIME) ? dtpm_pkg::MAX_DEAD_TIME : k_dead;
    acc = ((longint'(k_a) * longint'(scaled_ctrl_line[z])) >>> 16)
        + ((longint'(k_b) * longint'(scaled_ctrl_line[z+1])) >>> 16)
        + ((longint'(k_c) * longint'(scaled_ctrl_line[z+2])) >>> 16)
        + ((longint'(k_fb) * longint'(y_older)) >>> 8);
    y = acc >>> 8;
    if (y < 0) begin
      r.plant_out = '0;
      r.flag = dtpm_pkg::FLAG_LOW;
    end else if (y > longint'(dtpm_pkg::OUT_MAX)) begin
      r.plant_out = dtpm_pkg::OUT_MAX;
      r.flag = dtpm_pkg::FLAG_HIGH;
    end else begin
      r.plant_out = y[dtpm_pkg::OUT_W-1:0];
      r.flag = dtpm_pkg::FLAG_NONE;
    end
    y_older  = y_newest;
    y_newest = r.plant_out;
    return r;
  endfunction

  // mostly short, now and then a long one
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic write_reg(input logic [dtpm_pkg::IDX_W-1:0] idx,
                           input logic [dtpm_pkg::COEF_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      dtpm_pkg::REG_GAIN:      k_gain = value;
      dtpm_pkg::REG_COEF_A:    k_a    = value;
      dtpm_pkg::REG_COEF_B:    k_b    = value;
      dtpm_pkg::REG_COEF_C:    k_c    = value;
      dtpm_pkg::REG_FEEDBACK:  k_fb   = value;
      dtpm_pkg::REG_DEAD_TIME: k_dead = value[dtpm_pkg::DT_W-1:0];
      default: ;
    endcase
  endtask

  // hold the sender until every result is out and the block has gone quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (plant_outputs_due.size() != 0) @(posedge clk);
    repeat (2 * STEP_CYCLES) @(posedge clk);
  endtask

  task automatic send_control(input logic [dtpm_pkg::CTRL_W-1:0] u, input logic use_fixed,
                              input plant_result_t fixed_result);
    int unsigned   gap;
    plant_result_t want;
    gap = sender_burst ? 0 : (($urandom_range(0, 99) < 40) ? idle_length() : 0);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.control_in <= u;
    do @(posedge clk); while (!in_ch.ready);
    want = plant_step(u);
    if (use_fixed) want = fixed_result;
    plant_outputs_due = {plant_outputs_due, want};
  endtask

  task automatic note_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // receiver: random stalls, rate set per phase
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < sink_stall_pct) begin
      sink_hold = idle_length() - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    plant_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (plant_outputs_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected transfer, actual plant_out %0d clamp_flag %0d",
                   $time, out_ch.plant_out, out_ch.clamp_flag);
      end else begin
        want = plant_outputs_due.pop_front();
        if (out_ch.plant_out !== want.plant_out)
          note_mismatch("plant_out", want.plant_out, out_ch.plant_out);
        if (out_ch.clamp_flag !== want.flag)
          note_mismatch("clamp_flag", want.flag, out_ch.clamp_flag);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_MAX);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [dtpm_pkg::COEF_W-1:0] v_gain, v_a, v_b, v_c, v_fb, v_dead;
    logic [dtpm_pkg::CTRL_W-1:0] u;
    cfg_mode_t                   mode;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.control_in = '0;
    out_ch.ready     = 1'b0;
    reset_plant_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
        settle();
        write_reg(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].data);
      end else begin
        send_control(DIRECTED_ROWS[i].ctrl, DIRECTED_ROWS[i].fixed,
                     '{DIRECTED_ROWS[i].want_out, DIRECTED_ROWS[i].want_flag});
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      mode = cfg_mode_t'(ph % 3);
      case (mode)
        CFG_PLAUSIBLE: begin
          v_gain = $urandom_range(100, 700);
          v_a    = dtpm_pkg::COEF_A_RST + 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
          v_b    = dtpm_pkg::COEF_B_RST + 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
          v_c    = dtpm_pkg::COEF_C_RST + 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
          v_fb   = $urandom_range(0, 32'h0001_0000);
        end
        CFG_SMALL: begin
          v_gain = 32'($urandom_range(0, 32'h0000_4000)) - 32'h0000_2000;
          v_a    = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
          v_b    = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
          v_c    = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
          v_fb   = 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;
        end
        default: begin
          v_gain = $urandom();
          v_a    = $urandom();
          v_b    = $urandom();
          v_c    = $urandom();
          v_fb   = $urandom();
        end
      endcase
      v_dead = $urandom_range(0, 15);
      write_reg(dtpm_pkg::REG_GAIN, v_gain);
      write_reg(dtpm_pkg::REG_COEF_A, v_a);
      write_reg(dtpm_pkg::REG_COEF_B, v_b);
      write_reg(dtpm_pkg::REG_COEF_C, v_c);
      write_reg(dtpm_pkg::REG_FEEDBACK, v_fb);
      write_reg(dtpm_pkg::REG_DEAD_TIME, v_dead);
      write_reg($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI, $urandom());
      case ($urandom_range(0, 3))
        0: sink_stall_pct = 0;
        1: sink_stall_pct = 10;
        2: sink_stall_pct = 30;
        default: sink_stall_pct = 60;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) sender_burst = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: u = 16'($urandom_range(0, 25600));
          5, 6:          u = 16'($urandom());
          7:             u = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          default:       u = 16'($urandom_range(0, 1024)) - 16'd512;
        endcase
        send_control(u, 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (plant_outputs_due.size() != 0) @(posedge clk);
    repeat (2 * STEP_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dtpm_pkg.sv
hdl/dtpm_in_if.sv
hdl/dtpm_out_if.sv
hdl/dtpm_mac.sv
hdl/dtpm_line.sv
hdl/dtpm_seq.sv
hdl/dead_time_plant_model_step.sv
tb/dead_time_plant_model_step_tb.sv
